// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the chunk receipt tracker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define CRT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/crt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunk receipt tracker package
// Sizes, field codes and shared types of the chunk receipt tracker.
// ---------------------------------------------------------------------------
package crt_pkg;

    localparam int MAP_ENTRIES = 16384;
    localparam int CHUNK_BYTES = 1440;

    localparam int ROW_W  = 32;
    localparam int ROWS   = (MAP_ENTRIES + ROW_W - 1) / ROW_W;
    localparam int ROW_AW = $clog2(ROWS);
    localparam int BIT_W  = $clog2(ROW_W);
    localparam int IDX_W  = ROW_AW + BIT_W;

    localparam longint CAPACITY = longint'(MAP_ENTRIES) * longint'(CHUNK_BYTES);
    localparam int TOT_W   = $clog2(CAPACITY + 1);
    localparam int CHUNK_W = $clog2(CHUNK_BYTES + 1);
    localparam int OFS_W   = IDX_W + CHUNK_W;

    // Reciprocal of the chunk size, exact for every dividend below the capacity.
    localparam int     RECIP_SHIFT = TOT_W + CHUNK_W;
    localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + CHUNK_BYTES - 1)
                                     / CHUNK_BYTES;
    localparam int     RECIP_W     = $clog2(RECIP + 1);
    localparam int     PROD_W      = TOT_W + RECIP_W + 1;

    localparam int KIND_W    = 2;
    localparam int ADDRESS_W = 32;
    localparam int LEN_W     = 32;
    localparam int BYTES_W   = 11;

    localparam int IN_TDATA_W   = ADDRESS_W + LEN_W;
    localparam int OUT_BYTES_LO = ADDRESS_W;
    localparam int OUT_DONE_BIT = ADDRESS_W + BYTES_W;
    localparam int OUT_USED_W   = ADDRESS_W + BYTES_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;

    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PART  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic REPLY_ACK   = 1'b0;
    localparam logic REPLY_QUERY = 1'b1;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } part_idx_t;

endpackage

// ===== hw/rtl/chunk_receipt_tracker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Chunk receipt tracker
// Receive bitmap for a transfer cut into fixed chunks, with first-gap search.
// ---------------------------------------------------------------------------
// Items arrive on the s_ channel: tuser carries the kind (start, part, query),
// tdata the address and, for a start, the total length. Replies leave on the
// m_ channel: tuser is the reply kind, tdata the first missing chunk's address
// and length and the completion flag.
// The block works on one item at a time. A part beat goes through the index
// unit and, if its address lies inside the map, a read and a write-back of
// one map row. A start beat clears the map row by row and then replies. A
// query reads and evaluates the map one 32-bit row at a time until a clear
// bit or the last row, then forms the reply from the first clear bit, if any.
// After reset the same clearing pass runs with s_tready low.
// Replies sit in an output register; a new beat is taken while a reply waits,
// and the block only holds in its reply state if the next reply finds the
// register still full because the receiver stalls.
// ---------------------------------------------------------------------------
module chunk_receipt_tracker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] address, [63:32] length_bytes
    input  logic [crt_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [1:0] kind
    input  logic [crt_pkg::KIND_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] chunk_address, [42:32] chunk_bytes, [43] complete, [47:44] zero
    output logic [crt_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // [0] reply_kind
    output logic [0:0]                       m_tuser
);
    import crt_pkg::*;

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b0000000001,
        ST_IDLE     = 10'b0000000010,
        ST_PART_MUL = 10'b0000000100,
        ST_PART_RD  = 10'b0000001000,
        ST_PART_WR  = 10'b0000010000,
        ST_SCAN_RD  = 10'b0000100000,
        ST_SCAN_EV  = 10'b0001000000,
        ST_SCAN_OFS = 10'b0010000000,
        ST_SCAN_RES = 10'b0100000000,
        ST_REPLY    = 10'b1000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDRESS_W-1:0]   base_reg, base_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic [ROW_AW-1:0]      row_reg, row_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [OFS_W-1:0]       offset_reg, offset_next;
    logic                   ack_pending_reg, ack_pending_next;
    logic                   res_kind_reg, res_kind_next;
    logic [ADDRESS_W-1:0]   res_addr_reg, res_addr_next;
    logic [BYTES_W-1:0]     res_bytes_reg, res_bytes_next;
    logic                   res_done_reg, res_done_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_tdata_reg, out_tdata_next;
    logic                   out_tuser_reg, out_tuser_next;

    logic                   out_load;
    logic                   part_load;
    logic [ADDRESS_W-1:0]   in_addr;
    logic [LEN_W-1:0]       in_len;
    logic [OFS_W-1:0]       remaining;
    logic                   zero_found;
    logic [BIT_W-1:0]       zero_bit;
    part_idx_t              part;

    logic                   ram_wr_en;
    logic [ROW_AW-1:0]      ram_wr_addr;
    logic [ROW_W-1:0]       ram_wr_data;
    logic                   ram_rd_en;
    logic [ROW_AW-1:0]      ram_rd_addr;
    logic [ROW_W-1:0]       ram_rd_data;

    assign in_addr  = s_tdata[ADDRESS_W-1:0];
    assign in_len   = s_tdata[ADDRESS_W +: LEN_W];
    assign s_tready = (state_reg == ST_IDLE);

    crt_part_index u_part_index (
        .aclk         (aclk),
        .load         (part_load),
        .address      (in_addr),
        .base_address (base_reg),
        .part         (part)
    );

    crt_map_ram #(
        .AW (ROW_AW),
        .DW (ROW_W)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Lowest clear bit of the row just read.
    always_comb begin
        zero_found = 1'b0;
        zero_bit   = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (!ram_rd_data[i]) begin
                zero_found = 1'b1;
                zero_bit   = BIT_W'(i);
            end
        end
    end

    assign remaining = OFS_W'(total_reg) - offset_reg;

    always_comb begin
        state_next       = state_reg;
        base_next        = base_reg;
        total_next       = total_reg;
        row_next         = row_reg;
        bit_next         = bit_reg;
        offset_next      = offset_reg;
        ack_pending_next = ack_pending_reg;
        res_kind_next    = res_kind_reg;
        res_addr_next    = res_addr_reg;
        res_bytes_next   = res_bytes_reg;
        res_done_next    = res_done_reg;
        out_load         = 1'b0;
        part_load        = 1'b0;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = row_reg;
        ram_wr_data      = '0;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = row_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_wr_en = 1'b1;
                if (row_reg == ROW_AW'(ROWS - 1)) begin
                    row_next   = '0;
                    state_next = ack_pending_reg ? ST_REPLY : ST_IDLE;
                end else begin
                    row_next = row_reg + ROW_AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        KIND_START: begin
                            base_next        = in_addr;
                            total_next       = (in_len > LEN_W'(CAPACITY)) ?
                                               TOT_W'(CAPACITY) : in_len[TOT_W-1:0];
                            ack_pending_next = 1'b1;
                            res_kind_next    = REPLY_ACK;
                            res_addr_next    = '0;
                            res_bytes_next   = '0;
                            res_done_next    = 1'b0;
                            row_next         = '0;
                            state_next       = ST_CLEAR;
                        end
                        KIND_PART: begin
                            part_load  = 1'b1;
                            state_next = ST_PART_MUL;
                        end
                        KIND_QUERY: begin
                            row_next   = '0;
                            state_next = ST_SCAN_RD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PART_MUL: begin
                state_next = ST_PART_RD;
            end
            ST_PART_RD: begin
                if (part.ok) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = part.idx[IDX_W-1:BIT_W];
                    state_next  = ST_PART_WR;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PART_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = part.idx[IDX_W-1:BIT_W];
                ram_wr_data = ram_rd_data | (ROW_W'(1) << part.idx[BIT_W-1:0]);
                state_next  = ST_IDLE;
            end
            ST_SCAN_RD: begin
                ram_rd_en  = 1'b1;
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                if (zero_found) begin
                    bit_next   = zero_bit;
                    state_next = ST_SCAN_OFS;
                end else if (row_reg == ROW_AW'(ROWS - 1)) begin
                    res_kind_next  = REPLY_QUERY;
                    res_addr_next  = '0;
                    res_bytes_next = '0;
                    res_done_next  = 1'b1;
                    state_next     = ST_REPLY;
                end else begin
                    row_next   = row_reg + ROW_AW'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_OFS: begin
                offset_next = OFS_W'({row_reg, bit_reg}) * OFS_W'(CHUNK_BYTES);
                state_next  = ST_SCAN_RES;
            end
            ST_SCAN_RES: begin
                res_kind_next = REPLY_QUERY;
                if (offset_reg >= OFS_W'(total_reg)) begin
                    res_addr_next  = '0;
                    res_bytes_next = '0;
                    res_done_next  = 1'b1;
                end else begin
                    res_addr_next  = base_reg + ADDRESS_W'(offset_reg);
                    res_bytes_next = (remaining > OFS_W'(CHUNK_BYTES)) ?
                                     BYTES_W'(CHUNK_BYTES) : BYTES_W'(remaining);
                    res_done_next  = 1'b0;
                end
                state_next = ST_REPLY;
            end
            ST_REPLY: begin
                if (!out_valid_reg || m_tready) begin
                    out_load         = 1'b1;
                    ack_pending_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_tdata_next = out_tdata_reg;
        out_tuser_next = out_tuser_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_tdata_next = {{OUT_PAD_W{1'b0}}, res_done_reg, res_bytes_reg, res_addr_reg};
            out_tuser_next = res_kind_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            base_reg        <= '0;
            total_reg       <= '0;
            row_reg         <= '0;
            ack_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            base_reg        <= base_next;
            total_reg       <= total_next;
            row_reg         <= row_next;
            ack_pending_reg <= ack_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bit_reg       <= bit_next;
        offset_reg    <= offset_next;
        res_kind_reg  <= res_kind_next;
        res_addr_reg  <= res_addr_next;
        res_bytes_reg <= res_bytes_next;
        res_done_reg  <= res_done_next;
        out_tdata_reg <= out_tdata_next;
        out_tuser_reg <= out_tuser_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_tdata_reg;
    assign m_tuser[0] = out_tuser_reg;

    `CRT_ASSERT(a_idle_no_write, (state_reg == ST_IDLE) |-> !ram_wr_en,
                "map written while idle")
    `CRT_ASSERT_NEXT(a_part_rmw_row, (state_reg == ST_PART_RD) && part.ok,
                     ram_wr_en && (ram_wr_addr == $past(ram_rd_addr)),
                     "part write-back misses the row read")
    `CRT_ASSERT(a_done_is_empty, (m_tvalid && m_tdata[OUT_DONE_BIT]) |->
                ((m_tdata[ADDRESS_W-1:0] == '0) && (m_tdata[OUT_BYTES_LO +: BYTES_W] == '0)),
                "complete reply carries a chunk")
    `CRT_ASSERT(a_gap_length,
                (m_tvalid && (m_tuser[0] == REPLY_QUERY) && !m_tdata[OUT_DONE_BIT]) |->
                ((m_tdata[OUT_BYTES_LO +: BYTES_W] != '0) &&
                 (m_tdata[OUT_BYTES_LO +: BYTES_W] <= BYTES_W'(CHUNK_BYTES))),
                "missing chunk length out of range")

endmodule

// ===== hw/rtl/crt_map_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Receipt map memory
// Simple dual-port synchronous RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module crt_map_ram #(
    parameter int AW = 9,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [0:(1 << AW)-1];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/crt_part_index.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Part index unit
// Two-stage pipeline turning a part address into a chunk index of the map.
// ---------------------------------------------------------------------------
module crt_part_index (
    input  logic                           aclk,
    input  logic                           load,
    input  logic [crt_pkg::ADDRESS_W-1:0]  address,
    input  logic [crt_pkg::ADDRESS_W-1:0]  base_address,
    output crt_pkg::part_idx_t             part
);
    import crt_pkg::*;

    logic [ADDRESS_W-1:0] diff;
    logic                 ok_reg;
    logic [TOT_W-1:0]     diff_reg;
    logic [PROD_W-1:0]    prod;
    part_idx_t            part_reg;

    assign diff = address - base_address;

    // The offset is registered on load; ok marks one inside the capacity.
    always_ff @(posedge aclk) begin
        if (load) begin
            ok_reg   <= (address >= base_address) && (diff < ADDRESS_W'(CAPACITY));
            diff_reg <= diff[TOT_W-1:0];
        end
    end

    assign prod = PROD_W'(diff_reg) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        part_reg.ok  <= ok_reg;
        part_reg.idx <= prod[RECIP_SHIFT +: IDX_W];
    end

    assign part = part_reg;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunk receipt tracker testbench
// Sends start, part, query and unused-kind beats with random stalls on both channels,
// keeps its own copy of the receipt bitmap and checks every reply against it or a fixed one.
// ---------------------------------------------------------------------------
module tb;
    import crt_pkg::*;

    localparam int          ITEM_TARGET  = 1700;
    localparam int          CALM_TAIL    = 250;
    localparam int          HOLD_CYCLES  = 5000;
    localparam int          DRAIN_CYCLES = 1100;
    localparam int          MAX_REPORTS  = 10;
    localparam int          MAX_PARTS    = 48;
    localparam int          DIR_ROWS     = 25;
    localparam int unsigned CAP_BYTES    = 32'(CAPACITY);

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic                 rkind;
        logic [ADDRESS_W-1:0] caddr;
        logic [BYTES_W-1:0]   cbytes;
        logic                 done;
    } reply_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ADDRESS_W-1:0] addr;
        logic [LEN_W-1:0]     len;
        logic                 typed;
        reply_t               want;
    } stim_row_t;

    localparam reply_t ACK_REPLY  = '{REPLY_ACK, 32'd0, 11'd0, 1'b0};
    localparam reply_t DONE_REPLY = '{REPLY_QUERY, 32'd0, 11'd0, 1'b1};

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;

    logic [ADDRESS_W-1:0] xfer_base  = '0;
    logic [TOT_W-1:0]     xfer_total = '0;
    bit                   rx_map [MAP_ENTRIES];

    reply_t replies_due [$];
    reply_t seen_reply;
    reply_t due_reply;
    int     fault_count = 0;
    int     beats_sent  = 0;
    bit     idle_on     = 1'b1;
    bit     hold_req    = 1'b0;

    stim_row_t dir_plan [DIR_ROWS] = '{
        '{KIND_QUERY, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, DONE_REPLY},
        '{KIND_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{KIND_START, 32'h0000_0000, 32'h0000_0000, 1'b1, ACK_REPLY},
        '{KIND_QUERY, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, DONE_REPLY},
        '{KIND_START, 32'h0000_1000, 32'hFFFF_FFFF, 1'b1, ACK_REPLY},
        '{KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{REPLY_QUERY, 32'h0000_1000, 11'd1440, 1'b0}},
        '{KIND_PART,  32'h0000_1005, 32'h0000_0000, 1'b0, '0},
        '{KIND_PART,  32'h0000_0FFF, 32'h0000_0000, 1'b0, '0},
        '{KIND_PART,  32'h0168_1000, 32'h0000_0000, 1'b0, '0},
        '{KIND_PART,  32'h0168_0A60, 32'h0000_0000, 1'b0, '0},
        '{KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{KIND_START, 32'hFFFF_F000, 32'd2880,      1'b1, ACK_REPLY},
        '{KIND_PART,  32'hFFFF_F000, 32'h0000_0000, 1'b0, '0},
        '{KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{KIND_PART,  32'hFFFF_FB3F, 32'h0000_0000, 1'b0, '0},
        '{KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{KIND_START, 32'h0000_0000, 32'd1441,      1'b1, ACK_REPLY},
        '{KIND_PART,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{KIND_PART,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{KIND_START, 32'h8000_0000, 32'h0168_0000, 1'b1, ACK_REPLY},
        '{KIND_PART,  32'h8000_059F, 32'h0000_0000, 1'b0, '0},
        '{KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{KIND_NONE,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b0, '0}
    };

    chunk_receipt_tracker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Updates the bitmap copy for one accepted beat and forms its reply, if any.
    function automatic logic advance_tracker(input logic [KIND_W-1:0] kind,
                                             input logic [ADDRESS_W-1:0] addr,
                                             input logic [LEN_W-1:0] len,
                                             output reply_t rep);
        longint unsigned      n_chunks;
        longint unsigned      pos;
        longint unsigned      ofs;
        logic [ADDRESS_W-1:0] rel;
        logic                 has;
        rep = '0;
        has = 1'b0;
        case (kind)
            KIND_START: begin
                xfer_base  = addr;
                xfer_total = (len > CAP_BYTES) ? TOT_W'(CAP_BYTES) : TOT_W'(len);
                foreach (rx_map[i]) rx_map[i] = 1'b0;
                rep = ACK_REPLY;
                has = 1'b1;
            end
            KIND_PART: begin
                if (addr >= xfer_base) begin
                    rel = addr - xfer_base;
                    pos = rel / CHUNK_BYTES;
                    if (pos < MAP_ENTRIES) rx_map[pos] = 1'b1;
                end
            end
            KIND_QUERY: begin
                n_chunks = (xfer_total + CHUNK_BYTES - 1) / CHUNK_BYTES;
                if (n_chunks > MAP_ENTRIES) n_chunks = MAP_ENTRIES;
                pos = 0;
                while (pos < n_chunks && rx_map[pos]) pos++;
                rep.rkind = REPLY_QUERY;
                if (pos == n_chunks) begin
                    rep.done = 1'b1;
                end else begin
                    ofs        = pos * CHUNK_BYTES;
                    rep.caddr  = xfer_base + ofs[ADDRESS_W-1:0];
                    rep.cbytes = (pos + 1 == n_chunks) ? BYTES_W'(xfer_total - ofs)
                                                       : BYTES_W'(CHUNK_BYTES);
                end
                has = 1'b1;
            end
            default: has = 1'b0;
        endcase
        return has;
    endfunction

    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endtask

    task automatic offer_beat(input logic [KIND_W-1:0] kind,
                              input logic [ADDRESS_W-1:0] addr,
                              input logic [LEN_W-1:0] len,
                              input logic typed,
                              input reply_t want);
        reply_t rep;
        int     gap;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {len, addr};
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (advance_tracker(kind, addr, len, rep))
            replies_due.push_back(typed ? want : rep);
        if (kind != KIND_NONE) beats_sent++;
    endtask

    task automatic offer_noise(input logic [ADDRESS_W-1:0] base);
        case ($urandom_range(0, 9))
            0, 1:    offer_beat(KIND_NONE, $urandom, $urandom, 1'b0, '0);
            2, 3:    offer_beat(KIND_PART, $urandom, $urandom, 1'b0, '0);
            4, 5:    offer_beat(KIND_PART, base - $urandom_range(1, 5000), $urandom, 1'b0, '0);
            6, 7:    offer_beat(KIND_PART, base + $urandom_range(0, 20000) * CHUNK_BYTES,
                                $urandom, 1'b0, '0);
            8:       offer_beat(KIND_QUERY, $urandom, $urandom, 1'b0, '0);
            default: offer_beat(KIND_START, $urandom, $urandom, 1'b0, '0);
        endcase
    endtask

    // One transfer: a start, parts of up to MAX_PARTS chunks in random order with
    // queries and noise mixed in, and a closing query; half may drop parts.
    task automatic run_transfer();
        logic [ADDRESS_W-1:0] base;
        logic [LEN_W-1:0]     total;
        int                   n_chunks;
        int                   n_parts;
        int                   pick;
        int                   tmp;
        int                   i;
        bit                   leave_gaps;
        int                   order [MAX_PARTS];
        base = $urandom;
        case ($urandom_range(0, 19))
            0:       total = $urandom;
            1:       total = $urandom_range(0, CAP_BYTES);
            2, 3:    total = CHUNK_BYTES * $urandom_range(1, 24);
            4:       total = $urandom_range(0, CHUNK_BYTES);
            default: total = $urandom_range(1, 40 * CHUNK_BYTES);
        endcase
        offer_beat(KIND_START, base, total, 1'b0, '0);
        n_chunks = (total > CAP_BYTES) ? MAP_ENTRIES : (total + CHUNK_BYTES - 1) / CHUNK_BYTES;
        n_parts = (n_chunks < MAX_PARTS) ? n_chunks : MAX_PARTS;
        leave_gaps = $urandom_range(0, 1);
        for (i = 0; i < n_parts; i++) order[i] = i;
        for (i = n_parts - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[pick];
            order[pick] = tmp;
        end
        for (i = 0; i < n_parts; i++) begin
            if (!(leave_gaps && $urandom_range(0, 5) == 0))
                offer_beat(KIND_PART, base + order[i] * CHUNK_BYTES
                           + $urandom_range(0, CHUNK_BYTES - 1), $urandom, 1'b0, '0);
            if ($urandom_range(0, 7) == 0) offer_beat(KIND_QUERY, $urandom, $urandom, 1'b0, '0);
            if ($urandom_range(0, 11) == 0) offer_noise(base);
        end
        offer_beat(KIND_QUERY, $urandom, $urandom, 1'b0, '0);
    endtask

    // Receiver: random stalls, plus one long hold-off so that the reply
    // register fills and the block stops taking beats.
    initial begin
        int stall;
        bit held;
        m_tready = 1'b0;
        held = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            seen_reply = '{m_tuser[0], m_tdata[ADDRESS_W-1:0],
                           m_tdata[OUT_DONE_BIT-1:OUT_BYTES_LO], m_tdata[OUT_DONE_BIT]};
            if (replies_due.size() == 0) begin
                log_fault($sformatf("unexpected reply: kind %0d addr %h bytes %0d done %0d",
                                    seen_reply.rkind, seen_reply.caddr,
                                    seen_reply.cbytes, seen_reply.done));
            end else begin
                due_reply = replies_due.pop_front();
                if (seen_reply.rkind !== due_reply.rkind || seen_reply.caddr !== due_reply.caddr
                    || seen_reply.cbytes !== due_reply.cbytes
                    || seen_reply.done !== due_reply.done)
                    log_fault($sformatf({"reply mismatch: expected kind %0d addr %h bytes %0d ",
                                         "done %0d, got kind %0d addr %h bytes %0d done %0d"},
                                        due_reply.rkind, due_reply.caddr, due_reply.cbytes,
                                        due_reply.done, seen_reply.rkind, seen_reply.caddr,
                                        seen_reply.cbytes, seen_reply.done));
            end
        end
    end

    initial begin
        int row;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        for (row = 0; row < DIR_ROWS; row++)
            offer_beat(dir_plan[row].kind, dir_plan[row].addr, dir_plan[row].len,
                       dir_plan[row].typed, dir_plan[row].want);
        hold_req = 1'b1;
        while (beats_sent < ITEM_TARGET) begin
            if (beats_sent > ITEM_TARGET - CALM_TAIL) idle_on = 1'b0;
            run_transfer();
        end
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
